@@ rtl/dtv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dtv_pkg;

   // Width of the year accumulator; a year above its all-ones value is rejected.
   localparam int YEAR_BITS = 16;
   localparam int YEAR_MUL_BITS = YEAR_BITS + 4;

   // Widths of the result fields.
   localparam int DAY_BITS = 5;
   localparam int MONTH_BITS = 4;
   localparam int OUT_YEAR_BITS = 16;

   // Character codes.
   localparam logic [7:0] SLASH_CODE = 8'h2F;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] DIGIT_NINE = 8'h39;

   // Saturation caps of the day and month accumulators.
   localparam logic [5:0] DAY_CAP = 6'd63;
   localparam logic [3:0] MONTH_CAP = 4'd15;
   localparam logic [3:0] MONTH_MAX = 4'd12;

   localparam logic [1:0] SLASH_COUNT_MAX = 2'd3;
   localparam logic [1:0] SLASH_COUNT_OK = 2'd2;

   // Month codes with a length other than 31.
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;

   function automatic logic [DAY_BITS-1:0] month_days(input logic [3:0] month,
                                                       input logic leap);
      logic [DAY_BITS-1:0] days;
      case (month)
         MONTH_FEB: days = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = 5'd30;
         default: days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

@@ rtl/date_text_validator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A character accepted into the input stage is processed from there; for the last
// character of a text the result is registered into the result stage and shown on rsp_*.
// Throughput: one character per cycle, but a last character waits while a result stalls.
// Reset (synchronous, active high) empties both stages and clears all parse state.
module date_text_validator_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [7:0]                      req_char_code,
   input  wire logic                            req_last_char,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_date_valid,
   output logic [dtv_pkg::DAY_BITS-1:0]         rsp_day_value,
   output logic [dtv_pkg::MONTH_BITS-1:0]       rsp_month_value,
   output logic [dtv_pkg::OUT_YEAR_BITS-1:0]    rsp_year_value
);
   import dtv_pkg::*;

   // Input stage.
   logic                 s1_valid_ff, s1_valid_in;
   logic [7:0]           s1_char_ff;
   logic                 s1_last_ff;

   // Parse state.
   logic [1:0]           slash_ff, slash_in, slash_upd;
   logic [5:0]           day_ff, day_in, day_upd;
   logic [3:0]           month_ff, month_in, month_upd;
   logic [YEAR_BITS-1:0] year_ff, year_in, year_upd;
   logic [2:0]           present_ff, present_in, present_upd;
   logic                 bad_ff, bad_in, bad_upd;
   logic [1:0]           ymod4_ff, ymod4_in, ymod4_upd;   // year mod 4
   logic [1:0]           cent_ff, cent_in, cent_upd;      // (year / 100) mod 4
   logic [3:0]           tens_ff, tens_in, tens_upd;
   logic [3:0]           units_ff, units_in, units_upd;

   // Result stage.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     date_ok_ff;
   logic [DAY_BITS-1:0]      day_out_ff;
   logic [MONTH_BITS-1:0]    month_out_ff;
   logic [OUT_YEAR_BITS-1:0] year_out_ff;

   logic                     proc_go;
   logic                     is_slash;
   logic                     is_digit;
   logic [3:0]               digit;
   logic [9:0]               day_mul;
   logic [7:0]               month_mul;
   logic [YEAR_MUL_BITS-1:0] year_mul;
   logic                     year_ovf;
   logic                     leap;
   logic                     date_ok;
   logic [YEAR_BITS+OUT_YEAR_BITS-1:0] year_wide;

   // A last character needs room in the result register; others always advance.
   assign proc_go   = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || proc_go;

   assign is_slash = (s1_char_ff == SLASH_CODE);
   assign is_digit = (s1_char_ff >= DIGIT_ZERO) && (s1_char_ff <= DIGIT_NINE);
   assign digit    = s1_char_ff[3:0];

   assign day_mul   = ({4'd0, day_ff} << 3) + ({4'd0, day_ff} << 1) + {6'd0, digit};
   assign month_mul = ({4'd0, month_ff} << 3) + ({4'd0, month_ff} << 1) + {4'd0, digit};
   assign year_mul  = ({4'd0, year_ff} << 3) + ({4'd0, year_ff} << 1)
                      + {{YEAR_BITS{1'b0}}, digit};
   assign year_ovf  = |year_mul[YEAR_MUL_BITS-1:YEAR_BITS];

   always_comb begin
      slash_upd   = slash_ff;
      day_upd     = day_ff;
      month_upd   = month_ff;
      year_upd    = year_ff;
      present_upd = present_ff;
      bad_upd     = bad_ff;
      ymod4_upd   = ymod4_ff;
      cent_upd    = cent_ff;
      tens_upd    = tens_ff;
      units_upd   = units_ff;
      if (is_slash) begin
         if (slash_ff != SLASH_COUNT_MAX) begin
            slash_upd = slash_ff + 2'd1;
         end
      end else if (is_digit) begin
         case (slash_ff)
            2'd0: begin
               day_upd = (day_mul > {4'd0, DAY_CAP}) ? DAY_CAP : day_mul[5:0];
               present_upd[0] = 1'b1;
            end
            2'd1: begin
               month_upd = (month_mul > {4'd0, MONTH_CAP}) ? MONTH_CAP : month_mul[3:0];
               present_upd[1] = 1'b1;
            end
            2'd2: begin
               if (year_ovf) begin
                  bad_upd  = 1'b1;
                  year_upd = '1;
               end else begin
                  year_upd = year_mul[YEAR_BITS-1:0];
               end
               // Track the residues the leap rule needs as each digit shifts in.
               ymod4_upd = {ymod4_ff[0], 1'b0} + digit[1:0];
               cent_upd  = {cent_ff[0], 1'b0} + tens_ff[1:0];
               tens_upd  = units_ff;
               units_upd = digit;
               present_upd[2] = 1'b1;
            end
            default: begin
               // drop digits after a third slash
            end
         endcase
      end else begin
         bad_upd = 1'b1;
      end
   end

   always_comb begin
      leap = ((tens_upd == 4'd0) && (units_upd == 4'd0)) ? (cent_upd == 2'd0)
                                                           : (ymod4_upd == 2'd0);
      date_ok = !bad_upd && (slash_upd == SLASH_COUNT_OK) && (present_upd == 3'b111)
                && (month_upd != 4'd0) && (month_upd <= MONTH_MAX)
                && (day_upd != 6'd0)
                && (day_upd <= {1'b0, month_days(month_upd, leap)});
      year_wide = {{OUT_YEAR_BITS{1'b0}}, year_upd};
   end

   // Clear the parse state after the last character of a text.
   always_comb begin
      slash_in   = s1_last_ff ? '0 : slash_upd;
      day_in     = s1_last_ff ? '0 : day_upd;
      month_in   = s1_last_ff ? '0 : month_upd;
      year_in    = s1_last_ff ? '0 : year_upd;
      present_in = s1_last_ff ? '0 : present_upd;
      bad_in     = s1_last_ff ? 1'b0 : bad_upd;
      ymod4_in   = s1_last_ff ? '0 : ymod4_upd;
      cent_in    = s1_last_ff ? '0 : cent_upd;
      tens_in    = s1_last_ff ? '0 : tens_upd;
      units_in   = s1_last_ff ? '0 : units_upd;

      s1_valid_in = (req_valid && req_ready) ? 1'b1 : (proc_go ? 1'b0 : s1_valid_ff);

      if (proc_go && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slash_ff     <= '0;
         day_ff       <= '0;
         month_ff     <= '0;
         year_ff      <= '0;
         present_ff   <= '0;
         bad_ff       <= 1'b0;
         ymod4_ff     <= '0;
         cent_ff      <= '0;
         tens_ff      <= '0;
         units_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (proc_go) begin
            slash_ff   <= slash_in;
            day_ff     <= day_in;
            month_ff   <= month_in;
            year_ff    <= year_in;
            present_ff <= present_in;
            bad_ff     <= bad_in;
            ymod4_ff   <= ymod4_in;
            cent_ff    <= cent_in;
            tens_ff    <= tens_in;
            units_ff   <= units_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_char_ff <= req_char_code;
         s1_last_ff <= req_last_char;
      end
      if (proc_go && s1_last_ff) begin
         date_ok_ff   <= date_ok;
         day_out_ff   <= date_ok ? day_upd[DAY_BITS-1:0] : '0;
         month_out_ff <= date_ok ? month_upd : '0;
         year_out_ff  <= date_ok ? year_wide[OUT_YEAR_BITS-1:0] : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_date_valid  = date_ok_ff;
   assign rsp_day_value   = day_out_ff;
   assign rsp_month_value = month_out_ff;
   assign rsp_year_value  = year_out_ff;

endmodule

`default_nettype wire

@@ rtl/dtv_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtv_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic [7:0]                      req_char_code,
   input wire logic                            req_last_char,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic                            rsp_date_valid,
   input wire logic [dtv_pkg::DAY_BITS-1:0]    rsp_day_value,
   input wire logic [dtv_pkg::MONTH_BITS-1:0]  rsp_month_value,
   input wire logic [dtv_pkg::OUT_YEAR_BITS-1:0] rsp_year_value
);
   import dtv_pkg::*;

   // A stalled result transaction holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_date_valid)
         && $stable(rsp_day_value) && $stable(rsp_month_value) && $stable(rsp_year_value))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_date_valid |->
         rsp_day_value == '0 && rsp_month_value == '0 && rsp_year_value == '0)
      else $error("invalid date with nonzero fields");

   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_date_valid |->
         rsp_month_value != '0 && rsp_month_value <= MONTH_MAX && rsp_day_value != '0)
      else $error("valid date out of range");

   a_feb_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_date_valid && rsp_month_value == MONTH_FEB |->
         rsp_day_value <= 5'd29)
      else $error("february day too large");

endmodule

bind date_text_validator_core dtv_checker u_dtv_checker (.*);

`default_nettype wire
